>>> rtl/mlqs_pkg.sv
// shared types, constants and helpers for the multilevel queue scheduler
// used by mlqs_ctrl, mlqs_dp and the top level in rtl/; depends on nothing
package mlqs_pkg;

  localparam int NumProcs  = 16;
  localparam int NumLevels = 3;
  localparam int PidW      = 4;
  localparam int CatW      = 2;
  localparam int BurstW    = 16;
  localparam int ClockW    = 24;
  localparam int QuantW    = 8;
  localparam int IdxW      = $clog2(NumProcs);
  localparam int CntW      = $clog2(NumProcs + 1);
  localparam int RamDepth  = NumLevels * NumProcs;
  localparam int RamAw     = $clog2(RamDepth);

  localparam logic [ClockW-1:0] ClockMax   = {ClockW{1'b1}};
  localparam logic [QuantW-1:0] QuantReset = QuantW'(2);

  // mode codes
  localparam logic ModeAdmit    = 1'b0;
  localparam logic ModeDispatch = 1'b1;

  // fifo index of the background level
  localparam logic [1:0] QBackground = 2'd0;

  typedef enum logic [1:0] {
    StAdmitted = 2'd0,
    StRejected = 2'd1,
    StRun      = 2'd2,
    StIdle     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADMIT,
    S_REQUEUE,
    S_SELECT,
    S_RUN
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic admit;
    logic requeue;
    logic select;
    logic emit_idle;
    logic run;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_mode;
    logic out_free;
    logic any_queued;
  } sts_t;

  // flat slot address of one fifo entry
  function automatic logic [RamAw-1:0] slot_addr(logic [1:0] q, logic [IdxW-1:0] idx);
    logic [RamAw-1:0] a;
    a = RamAw'(q) * RamAw'(NumProcs) + RamAw'(idx);
    return a;
  endfunction

  function automatic logic [IdxW-1:0] wrap_next(logic [IdxW-1:0] idx);
    logic [IdxW-1:0] n;
    n = (idx == IdxW'(NumProcs - 1)) ? '0 : idx + IdxW'(1);
    return n;
  endfunction

endpackage

>>> rtl/mlqs_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module mlqs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/mlqs_ctrl.sv
// sequencing state machine of the scheduler
// depends on mlqs_pkg
module mlqs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  mlqs_pkg::sts_t sts_i,
  output mlqs_pkg::cmd_t cmd_o
);

  mlqs_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mlqs_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mlqs_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = (sts_i.in_mode == mlqs_pkg::ModeDispatch) ? mlqs_pkg::S_REQUEUE
                                                               : mlqs_pkg::S_ADMIT;
        end
      end
      mlqs_pkg::S_ADMIT: begin
        if (sts_i.out_free) state_d = mlqs_pkg::S_IDLE;
      end
      mlqs_pkg::S_REQUEUE: begin
        state_d = mlqs_pkg::S_SELECT;
      end
      mlqs_pkg::S_SELECT: begin
        if (sts_i.any_queued) begin
          state_d = mlqs_pkg::S_RUN;
        end else if (sts_i.out_free) begin
          state_d = mlqs_pkg::S_IDLE;
        end
      end
      mlqs_pkg::S_RUN: begin
        if (sts_i.out_free) state_d = mlqs_pkg::S_IDLE;
      end
      default: state_d = mlqs_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      mlqs_pkg::S_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      mlqs_pkg::S_ADMIT:   cmd_o.admit = sts_i.out_free;
      mlqs_pkg::S_REQUEUE: cmd_o.requeue = 1'b1;
      mlqs_pkg::S_SELECT: begin
        cmd_o.select    = sts_i.any_queued;
        cmd_o.emit_idle = !sts_i.any_queued && sts_i.out_free;
      end
      mlqs_pkg::S_RUN:     cmd_o.run = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

>>> rtl/mlqs_dp.sv
// datapath of the scheduler: process table, level fifos, clock, result register
// depends on mlqs_pkg and mlqs_ram
module mlqs_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  mlqs_pkg::cmd_t                  cmd_i,
  output mlqs_pkg::sts_t                  sts_o,
  input  logic                            cfg_we_i,
  input  logic [mlqs_pkg::QuantW-1:0]     cfg_wdata_i,
  input  logic                            mode_i,
  input  logic [mlqs_pkg::PidW-1:0]       pid_i,
  input  logic [mlqs_pkg::CatW-1:0]       category_i,
  input  logic [mlqs_pkg::BurstW-1:0]     burst_i,
  input  logic [mlqs_pkg::ClockW-1:0]     arrival_time_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      status_o,
  output logic [mlqs_pkg::PidW-1:0]       out_pid_o,
  output logic [1:0]                      level_o,
  output logic [mlqs_pkg::BurstW-1:0]     run_length_o,
  output logic [mlqs_pkg::ClockW-1:0]     end_time_o,
  output logic                            finished_o
);

  localparam int NP = mlqs_pkg::NumProcs;
  localparam int NL = mlqs_pkg::NumLevels;
  localparam int IW = mlqs_pkg::IdxW;
  localparam int CW = mlqs_pkg::CntW;
  localparam int BW = mlqs_pkg::BurstW;
  localparam int TW = mlqs_pkg::ClockW;
  localparam int PW = mlqs_pkg::PidW;

  // configuration and architectural state
  logic [mlqs_pkg::QuantW-1:0] quantum_q;
  logic [TW-1:0]               clock_q, clock_d;
  logic [BW-1:0]               remaining_q [NP];
  logic [1:0]                  level_of_q [NP];
  logic [NP-1:0]               active_q;
  logic [IW-1:0]               head_q [NL];
  logic [IW-1:0]               tail_q [NL];
  logic [CW-1:0]               count_q [NL];
  logic [IW-1:0]               held_pid_q;
  logic                        held_valid_q;

  // latched input transaction
  logic                        mode_q;
  logic [PW-1:0]               pid_q;
  logic [mlqs_pkg::CatW-1:0]   cat_q;
  logic [BW-1:0]               burst_q;
  logic [TW-1:0]               arr_q;
  logic [1:0]                  selq_q;

  // result register
  logic                        out_valid_q;
  mlqs_pkg::status_e           status_q, status_d;
  logic [PW-1:0]               opid_q, opid_d;
  logic [1:0]                  level_q, level_d;
  logic [BW-1:0]               runlen_q, runlen_d;
  logic                        fin_q, fin_d;
  logic                        emit;

  // fifo push and pop controls
  logic                        push_en;
  logic [1:0]                  push_lvl;
  logic [IW-1:0]               push_pid;
  logic                        push_ok;
  logic [1:0]                  top_lvl;
  logic                        any_queued;
  logic [PW-1:0]               ram_rdata;
  logic [IW-1:0]               sel_pid;

  // admit and run arithmetic
  logic                        reject;
  logic [IW-1:0]               adm_idx;
  logic [BW-1:0]               rem_sel;
  logic [BW-1:0]               slice;
  logic [BW-1:0]               run_len;
  logic [TW:0]                 clk_sum;

  assign adm_idx = pid_q[IW-1:0];
  assign reject  = (32'(pid_q) >= NP) || active_q[adm_idx] || (burst_q == '0) || (cat_q == '0);

  // highest non-empty level
  always_comb begin
    any_queued = 1'b1;
    top_lvl    = mlqs_pkg::QBackground;
    priority if (count_q[2] != '0) top_lvl = 2'd2;
    else if (count_q[1] != '0)     top_lvl = 2'd1;
    else if (count_q[0] != '0)     top_lvl = 2'd0;
    else                           any_queued = 1'b0;
  end

  // push source: admission or requeue of the held process
  always_comb begin
    push_en  = 1'b0;
    push_lvl = '0;
    push_pid = adm_idx;
    if (cmd_i.admit && !reject) begin
      push_en  = 1'b1;
      push_lvl = cat_q - 2'd1;
    end else if (cmd_i.requeue && held_valid_q) begin
      push_en  = 1'b1;
      push_lvl = level_of_q[held_pid_q] - 2'd1;
      push_pid = held_pid_q;
    end
  end
  assign push_ok = push_en && (32'(count_q[push_lvl]) < NP);

  mlqs_ram #(
    .Width(PW),
    .Depth(mlqs_pkg::RamDepth)
  ) u_slots (
    .clk_i  (clk_i),
    .we_i   (push_ok),
    .waddr_i(mlqs_pkg::slot_addr(push_lvl, tail_q[push_lvl])),
    .wdata_i(PW'(push_pid)),
    .re_i   (cmd_i.select),
    .raddr_i(mlqs_pkg::slot_addr(top_lvl, head_q[top_lvl])),
    .rdata_o(ram_rdata)
  );

  // slice length and clock advance for the popped process
  assign sel_pid = ram_rdata[IW-1:0];
  assign rem_sel = remaining_q[sel_pid];
  assign slice   = (quantum_q == '0) ? BW'(1) : BW'(quantum_q);
  always_comb begin
    run_len = rem_sel;
    if (selq_q != mlqs_pkg::QBackground && rem_sel > slice) run_len = slice;
  end
  assign clk_sum = {1'b0, clock_q} + (TW + 1)'(run_len);

  // next clock
  always_comb begin
    clock_d = clock_q;
    if (cmd_i.admit && !reject && arr_q > clock_q) clock_d = arr_q;
    if (cmd_i.run) clock_d = clk_sum[TW] ? mlqs_pkg::ClockMax : clk_sum[TW-1:0];
  end

  // result fields
  always_comb begin
    emit     = 1'b0;
    status_d = status_q;
    opid_d   = opid_q;
    level_d  = level_q;
    runlen_d = runlen_q;
    fin_d    = fin_q;
    if (cmd_i.admit) begin
      emit     = 1'b1;
      status_d = reject ? mlqs_pkg::StRejected : mlqs_pkg::StAdmitted;
      opid_d   = pid_q;
      level_d  = reject ? 2'd0 : cat_q;
      runlen_d = '0;
      fin_d    = 1'b0;
    end else if (cmd_i.emit_idle) begin
      emit     = 1'b1;
      status_d = mlqs_pkg::StIdle;
      opid_d   = '0;
      level_d  = '0;
      runlen_d = '0;
      fin_d    = 1'b0;
    end else if (cmd_i.run) begin
      emit     = 1'b1;
      status_d = mlqs_pkg::StRun;
      opid_d   = PW'(sel_pid);
      level_d  = selq_q + 2'd1;
      runlen_d = run_len;
      fin_d    = (rem_sel == run_len);
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q    <= mlqs_pkg::QuantReset;
      clock_q      <= '0;
      active_q     <= '0;
      held_pid_q   <= '0;
      held_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < NL; i++) begin
        head_q[i]  <= '0;
        tail_q[i]  <= '0;
        count_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) quantum_q <= cfg_wdata_i;
      clock_q <= clock_d;
      // output slot
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      // fifo tail side
      if (push_ok) begin
        tail_q[push_lvl]  <= mlqs_pkg::wrap_next(tail_q[push_lvl]);
        count_q[push_lvl] <= count_q[push_lvl] + CW'(1);
      end
      // fifo head side, never the same cycle as a push
      if (cmd_i.select) begin
        head_q[top_lvl]  <= mlqs_pkg::wrap_next(head_q[top_lvl]);
        count_q[top_lvl] <= count_q[top_lvl] - CW'(1);
      end
      if (cmd_i.admit && !reject) active_q[adm_idx] <= 1'b1;
      if (cmd_i.requeue) held_valid_q <= 1'b0;
      if (cmd_i.run) begin
        if (rem_sel == run_len) begin
          active_q[sel_pid] <= 1'b0;
        end else begin
          held_pid_q   <= sel_pid;
          held_valid_q <= 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mode_q  <= mode_i;
      pid_q   <= pid_i;
      cat_q   <= category_i;
      burst_q <= burst_i;
      arr_q   <= arrival_time_i;
    end
    if (cmd_i.select) selq_q <= top_lvl;
    if (cmd_i.admit && !reject) begin
      remaining_q[adm_idx] <= burst_q;
      level_of_q[adm_idx]  <= cat_q;
    end
    if (cmd_i.run) remaining_q[sel_pid] <= rem_sel - run_len;
    status_q <= status_d;
    opid_q   <= opid_d;
    level_q  <= level_d;
    runlen_q <= runlen_d;
    fin_q    <= fin_d;
  end

  assign sts_o.in_mode    = mode_i;
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;
  assign sts_o.any_queued = any_queued && (mode_q == mlqs_pkg::ModeDispatch);

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign out_pid_o    = opid_q;
  assign level_o      = level_q;
  assign run_length_o = runlen_q;
  assign end_time_o   = clock_q;
  assign finished_o   = fin_q;

endmodule

>>> rtl/multilevel_queue_scheduler_unit.sv
// Multilevel queue scheduler, top level.
// Input channel (in_valid_i / in_stall_o) takes one transaction per item:
// mode 0 admits process pid_i at level category_i with burst_i and
// arrival_time_i; mode 1 dispatches one slice of the highest non-empty level.
// Output channel (out_valid_o / out_stall_i) returns exactly one result
// transaction per item: status, pid, level, run length, clock and finish flag.
// An admit writes its result from the admit state. A dispatch requeues the
// held process, reads the fifo head from the slot ram, then updates the slice
// and writes its result, or writes an idle result if no level holds a process.
// One item is in flight at a time; the next is taken once the sequencer is
// back in idle.
// A result waiting under out_stall_i holds; the sequencer finishes work up to
// the point of writing the next result and waits there.
// Reset (rst_ni low) empties every level, clears the clock and all process
// flags and sets quantum to 2. cfg_we_i writes the quantum; the user is to
// write it only while idle, as the block itself does not enforce this.
// Depends on mlqs_pkg, mlqs_ctrl, mlqs_dp and mlqs_ram.
module multilevel_queue_scheduler_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mlqs_pkg::QuantW-1:0]     cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            mode_i,
  input  logic [mlqs_pkg::PidW-1:0]       pid_i,
  input  logic [mlqs_pkg::CatW-1:0]       category_i,
  input  logic [mlqs_pkg::BurstW-1:0]     burst_i,
  input  logic [mlqs_pkg::ClockW-1:0]     arrival_time_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      status_o,
  output logic [mlqs_pkg::PidW-1:0]       out_pid_o,
  output logic [1:0]                      level_o,
  output logic [mlqs_pkg::BurstW-1:0]     run_length_o,
  output logic [mlqs_pkg::ClockW-1:0]     end_time_o,
  output logic                            finished_o
);

  mlqs_pkg::cmd_t cmd;
  mlqs_pkg::sts_t sts;

  // sequencer
  mlqs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // datapath
  mlqs_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .mode_i        (mode_i),
    .pid_i         (pid_i),
    .category_i    (category_i),
    .burst_i       (burst_i),
    .arrival_time_i(arrival_time_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .out_pid_o     (out_pid_o),
    .level_o       (level_o),
    .run_length_o  (run_length_o),
    .end_time_o    (end_time_o),
    .finished_o    (finished_o)
  );

endmodule

>>> dv/multilevel_queue_scheduler_unit_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the multilevel queue scheduler top level
// depends on mlqs_pkg and multilevel_queue_scheduler_unit
module multilevel_queue_scheduler_unit_tb;

  localparam int WatchLimit = 20000;
  localparam int NumRandom  = 850;

  typedef struct packed {
    logic        mode;
    logic [3:0]  pid;
    logic [1:0]  cat;
    logic [15:0] burst;
    logic [23:0] arr;
  } sched_req_t;

  typedef struct packed {
    mlqs_pkg::status_e status;
    logic [3:0]  pid;
    logic [1:0]  lvl;
    logic [15:0] run;
    logic [23:0] end_time;
    logic        fin;
  } sched_res_t;

  // directed row: request, quantum to set first (0 = keep), typed result if known
  typedef struct packed {
    sched_req_t req;
    logic [8:0] quant;
    logic       has_exp;
    sched_res_t exp;
  } dir_row_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [mlqs_pkg::QuantW-1:0] cfg_wdata_i;
  logic in_valid_i, in_stall_o;
  logic mode_i;
  logic [mlqs_pkg::PidW-1:0] pid_i;
  logic [mlqs_pkg::CatW-1:0] category_i;
  logic [mlqs_pkg::BurstW-1:0] burst_i;
  logic [mlqs_pkg::ClockW-1:0] arrival_time_i;
  logic out_valid_o, out_stall_i;
  logic [1:0] status_o;
  logic [mlqs_pkg::PidW-1:0] out_pid_o;
  logic [1:0] level_o;
  logic [mlqs_pkg::BurstW-1:0] run_length_o;
  logic [mlqs_pkg::ClockW-1:0] end_time_o;
  logic finished_o;

  multilevel_queue_scheduler_unit uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o,
    .mode_i, .pid_i, .category_i, .burst_i, .arrival_time_i,
    .out_valid_o, .out_stall_i, .status_o, .out_pid_o, .level_o,
    .run_length_o, .end_time_o, .finished_o
  );

  // scheduler shadow state
  logic [7:0]  quantum;
  logic [23:0] sim_clock;
  logic [15:0] rem_burst [mlqs_pkg::NumProcs];
  logic [1:0]  proc_level [mlqs_pkg::NumProcs];
  logic        busy [mlqs_pkg::NumProcs];
  logic [3:0]  ready_q [mlqs_pkg::NumLevels][$];
  logic [3:0]  parked_pid;
  logic        parked;

  sched_res_t expected_results [$];
  int errors;
  int idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic void reset_shadow();
    quantum = mlqs_pkg::QuantReset;
    sim_clock = '0;
    for (int i = 0; i < mlqs_pkg::NumProcs; i++) busy[i] = 1'b0;
    for (int l = 0; l < mlqs_pkg::NumLevels; l++) ready_q[l].delete();
    parked = 1'b0;
    parked_pid = '0;
  endfunction

  // compute the result of one transaction and update the shadow state
  function automatic sched_res_t schedule_step(sched_req_t r);
    sched_res_t o;
    logic [24:0] t;
    logic [15:0] slice, run;
    int q;
    logic [3:0] sel;
    o = '{mlqs_pkg::StIdle, 4'd0, 2'd0, 16'd0, 24'd0, 1'b0};
    if (r.mode == mlqs_pkg::ModeAdmit) begin
      if (busy[r.pid] || r.burst == 0 || r.cat == 0) begin
        o.status = mlqs_pkg::StRejected;
        o.pid = r.pid;
      end else begin
        if (r.arr > sim_clock) sim_clock = r.arr;
        busy[r.pid] = 1'b1;
        rem_burst[r.pid] = r.burst;
        proc_level[r.pid] = r.cat;
        if (ready_q[r.cat-1].size() < mlqs_pkg::NumProcs) ready_q[r.cat-1].push_back(r.pid);
        o.status = mlqs_pkg::StAdmitted;
        o.pid = r.pid;
        o.lvl = r.cat;
      end
      o.end_time = sim_clock;
      return o;
    end
    if (parked) begin
      if (ready_q[proc_level[parked_pid]-1].size() < mlqs_pkg::NumProcs)
        ready_q[proc_level[parked_pid]-1].push_back(parked_pid);
      parked = 1'b0;
    end
    q = -1;
    for (int l = mlqs_pkg::NumLevels - 1; l >= 0; l--)
      if (q < 0 && ready_q[l].size() != 0) q = l;
    if (q < 0) begin
      o.end_time = sim_clock;
      return o;
    end
    sel = ready_q[q].pop_front();
    run = rem_burst[sel];
    if (q != 0) begin
      slice = (quantum == 0) ? 16'd1 : 16'(quantum);
      if (run > slice) run = slice;
    end
    t = 25'(sim_clock) + 25'(run);
    sim_clock = (t > 25'(mlqs_pkg::ClockMax)) ? mlqs_pkg::ClockMax : t[23:0];
    rem_burst[sel] = rem_burst[sel] - run;
    o.status = mlqs_pkg::StRun;
    o.pid = sel;
    o.lvl = 2'(q + 1);
    o.run = run;
    o.end_time = sim_clock;
    if (rem_burst[sel] == 0) begin
      busy[sel] = 1'b0;
      o.fin = 1'b1;
    end else begin
      parked = 1'b1;
      parked_pid = sel;
    end
    return o;
  endfunction

  // send one transaction; burst/gap pattern on the sender side
  int burst_left;
  task automatic send_item(input sched_req_t r);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    mode_i <= r.mode;
    pid_i <= r.pid;
    category_i <= r.cat;
    burst_i <= r.burst;
    arrival_time_i <= r.arr;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_results.push_back(schedule_step(r));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_quantum(input logic [7:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    quantum = v;
  endtask

  // receiver: stall pattern with calm stretches
  always @(posedge clk_i) begin
    if (!rst_ni) out_stall_i <= 1'b0;
    else out_stall_i <= (($time / 3000) % 3 == 0) ? 1'b0 : ($urandom_range(0, 3) == 0);
  end

  // result checker
  always @(posedge clk_i) begin
    sched_res_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $display("unexpected result transaction at %0t", $time);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (status_o != e.status)
          report_mismatch("status", 32'(status_o), 32'(e.status));
        if (out_pid_o != e.pid)
          report_mismatch("pid", 32'(out_pid_o), 32'(e.pid));
        if (level_o != e.lvl)
          report_mismatch("level", 32'(level_o), 32'(e.lvl));
        if (run_length_o != e.run)
          report_mismatch("run_length", 32'(run_length_o), 32'(e.run));
        if (end_time_o != e.end_time)
          report_mismatch("end_time", 32'(end_time_o), 32'(e.end_time));
        if (finished_o != e.fin)
          report_mismatch("finished", 32'(finished_o), 32'(e.fin));
      end
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchLimit) begin
      $display("multilevel_queue_scheduler_unit test failed");
      $finish;
    end
  end

  function automatic sched_req_t rand_req(bit well_formed);
    sched_req_t r;
    r.mode = ($urandom_range(0, 9) < 5);
    r.pid = 4'($urandom_range(0, 15));
    r.cat = well_formed ? 2'($urandom_range(1, 3)) : 2'($urandom_range(0, 3));
    case ($urandom_range(0, 9))
      0: r.burst = well_formed ? 16'd1 : 16'd0;
      1: r.burst = 16'($urandom_range(0, 65535));
      2: r.burst = 16'hFFFF;
      default: r.burst = 16'($urandom_range(1, 12));
    endcase
    case ($urandom_range(0, 19))
      0: r.arr = mlqs_pkg::ClockMax;
      1: r.arr = 24'($urandom_range(0, 24'hFFFFFF));
      default: r.arr = sim_clock + 24'($urandom_range(0, 20));
    endcase
    return r;
  endfunction

  dir_row_t dir_rows [$];
  sched_res_t got;

  initial begin
    errors = 0;
    idle_cycles = 0;
    burst_left = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    mode_i = 1'b0;
    pid_i = '0;
    category_i = '0;
    burst_i = '0;
    arrival_time_i = '0;
    reset_shadow();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table: idle, admits, rejects, level order, saturation
    dir_rows = '{
      '{'{mlqs_pkg::ModeDispatch, 4'd0, 2'd0, 16'd0, 24'd0}, 9'd0, 1'b1,
        '{mlqs_pkg::StIdle, 4'd0, 2'd0, 16'd0, 24'd0, 1'b0}},
      '{'{mlqs_pkg::ModeAdmit, 4'd0, 2'd1, 16'd0, 24'd5}, 9'd0, 1'b1,
        '{mlqs_pkg::StRejected, 4'd0, 2'd0, 16'd0, 24'd0, 1'b0}},
      '{'{mlqs_pkg::ModeAdmit, 4'd1, 2'd0, 16'd5, 24'd5}, 9'd0, 1'b1,
        '{mlqs_pkg::StRejected, 4'd1, 2'd0, 16'd0, 24'd0, 1'b0}},
      '{'{mlqs_pkg::ModeAdmit, 4'd15, 2'd1, 16'd3, 24'd0}, 9'd0, 1'b0, '0},
      '{'{mlqs_pkg::ModeAdmit, 4'd15, 2'd2, 16'd3, 24'd0}, 9'd0, 1'b0, '0},
      '{'{mlqs_pkg::ModeAdmit, 4'd2, 2'd2, 16'd5, 24'd10}, 9'd0, 1'b0, '0},
      '{'{mlqs_pkg::ModeAdmit, 4'd3, 2'd3, 16'd4, 24'd10}, 9'd0, 1'b0, '0},
      '{'{mlqs_pkg::ModeDispatch, 4'd0, 2'd0, 16'd0, 24'd0}, 9'd0, 1'b0, '0},
      '{'{mlqs_pkg::ModeAdmit, 4'd4, 2'd3, 16'd1, 24'd0}, 9'd0, 1'b0, '0},
      '{'{mlqs_pkg::ModeDispatch, 4'd0, 2'd0, 16'd0, 24'd0}, 9'd0, 1'b0, '0},
      '{'{mlqs_pkg::ModeDispatch, 4'd0, 2'd0, 16'd0, 24'd0}, 9'd0, 1'b0, '0},
      '{'{mlqs_pkg::ModeDispatch, 4'd0, 2'd0, 16'd0, 24'd0}, 9'h100, 1'b0, '0},
      '{'{mlqs_pkg::ModeDispatch, 4'd0, 2'd0, 16'd0, 24'd0}, 9'd0, 1'b0, '0},
      '{'{mlqs_pkg::ModeDispatch, 4'd0, 2'd0, 16'd0, 24'd0}, 9'd0, 1'b0, '0},
      '{'{mlqs_pkg::ModeAdmit, 4'd5, 2'd2, 16'hFFFF, 24'hFFFFF0}, 9'h1FF, 1'b0, '0},
      '{'{mlqs_pkg::ModeDispatch, 4'd0, 2'd0, 16'd0, 24'd0}, 9'd0, 1'b0, '0},
      '{'{mlqs_pkg::ModeDispatch, 4'd0, 2'd0, 16'd0, 24'd0}, 9'd0, 1'b0, '0},
      '{'{mlqs_pkg::ModeAdmit, 4'd6, 2'd1, 16'hFFFF, 24'd0}, 9'd0, 1'b0, '0},
      '{'{mlqs_pkg::ModeDispatch, 4'd0, 2'd0, 16'd0, 24'd0}, 9'd0, 1'b0, '0},
      '{'{mlqs_pkg::ModeDispatch, 4'd0, 2'd0, 16'd0, 24'd0}, 9'd0, 1'b0, '0},
      '{'{mlqs_pkg::ModeDispatch, 4'd0, 2'd0, 16'd0, 24'd0}, 9'd0, 1'b0, '0}
    };
    // quant field: bit 8 set means write bits 7:0 first
    foreach (dir_rows[i]) begin
      if (dir_rows[i].quant[8]) write_quantum(dir_rows[i].quant[7:0]);
      send_item(dir_rows[i].req);
      if (dir_rows[i].has_exp) begin
        got = expected_results[$];
        if (got != dir_rows[i].exp) begin
          $display("directed row %0d disagrees with typed result", i);
          errors++;
        end
      end
    end
    // typed zero quantum acts as one
    write_quantum(8'd0);

    // random phases over several quantum settings
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_quantum(8'd1);
        1: write_quantum(8'd255);
        2: write_quantum(8'($urandom_range(2, 8)));
        3: write_quantum(8'd0);
        default: write_quantum(8'($urandom_range(1, 255)));
      endcase
      for (int n = 0; n < NumRandom / 5; n++) begin
        if (n == 40) drain();
        send_item(rand_req($urandom_range(0, 9) != 0));
      end
    end

    drain();
    if (errors == 0) begin
      $display("multilevel_queue_scheduler_unit test passed");
    end else begin
      $display("multilevel_queue_scheduler_unit test failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/mlqs_pkg.sv
rtl/mlqs_ram.sv
rtl/mlqs_ctrl.sv
rtl/mlqs_dp.sv
rtl/multilevel_queue_scheduler_unit.sv
dv/multilevel_queue_scheduler_unit_tb.sv
